// File: rtl/scr_pkg.sv
package scr_pkg;

  // field widths
  localparam int COORD_W = 24;
  localparam int SIZE_W  = 16;
  localparam int MOVE_W  = 16;
  localparam int LEN_W   = 32;

  // internal widths
  localparam int POS_W   = 28;   // positions stay exact across three sweeps
  localparam int DIFF_W  = 29;   // position minus rectangle centre
  localparam int OFF_W   = 18;   // leftover offsets reach +-65536
  localparam int MAG_W   = 17;   // magnitude of an offset
  localparam int SUM_W   = 34;   // sum of two squared magnitudes
  localparam int DIV_W   = 17;   // divider operand width

  // refinement iterations of the swept test
  localparam int SMALL_STEP_ITERS = 16;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [OFF_W-1:0]  off_t;
  typedef logic        [MAG_W-1:0]  mag_t;
  typedef logic        [SUM_W-1:0]  sum_t;

  function automatic mag_t off_abs(input off_t v);
    off_t n;
    n = -v;
    return v[OFF_W-1] ? mag_t'(n) : mag_t'(v);
  endfunction

endpackage

// File: rtl/scr_div.sv
module scr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [scr_pkg::DIV_W-1:0]   dividend,
  input  logic [scr_pkg::DIV_W-1:0]   divisor,
  output logic                        done,
  output logic [scr_pkg::DIV_W-1:0]   quotient
);
  import scr_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DIV_W:0]     rem_r;
  logic [DIV_W-1:0]   quo_r;
  logic [DIV_W-1:0]   dvs_r;
  logic [DIV_W:0]     trial;
  logic               fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses for one cycle after the last quotient bit
      done_r <= !start && busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= fits ? (trial - {1'b0, dvs_r}) : trial;
        quo_r <= {quo_r[DIV_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/swept_circle_rect_collision.sv
// Swept circle against an axis-aligned rectangle. One request carries the
// circle, the rectangle, a move offset and the caller's best squared length;
// one result comes back with the collision flag, reached position, allowed
// offset, squared length and whether it replaces the caller's result. The
// move is swept in full, then along the leftover x and y parts on hits. Each
// sweep walks coarse steps, counted as the larger offset part over the smallest
// size (raised to the register and to one), then refines by halving steps, at
// most 16 refine steps. All squaring and division run through one shared
// 17x17 squarer and one 17-bit serial divider under a sequencer, one request
// at a time. Three sweeps at most run per request. in_ready is high only
// while idle. cfg writes are taken at any time and must only be issued while
// idle.
module swept_circle_rect_collision (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [scr_pkg::COORD_W-1:0]  in_circle_x,
  input  logic signed [scr_pkg::COORD_W-1:0]  in_circle_y,
  input  logic        [scr_pkg::SIZE_W-1:0]   in_circle_radius,
  input  logic signed [scr_pkg::COORD_W-1:0]  in_rect_x,
  input  logic signed [scr_pkg::COORD_W-1:0]  in_rect_y,
  input  logic        [scr_pkg::SIZE_W-1:0]   in_rect_half_w,
  input  logic        [scr_pkg::SIZE_W-1:0]   in_rect_half_h,
  input  logic signed [scr_pkg::MOVE_W-1:0]   in_move_dx,
  input  logic signed [scr_pkg::MOVE_W-1:0]   in_move_dy,
  input  logic        [scr_pkg::LEN_W-1:0]    in_prior_length,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_hit,
  output logic signed [scr_pkg::COORD_W-1:0]  out_end_x,
  output logic signed [scr_pkg::COORD_W-1:0]  out_end_y,
  output logic signed [scr_pkg::MOVE_W-1:0]   out_allowed_dx,
  output logic signed [scr_pkg::MOVE_W-1:0]   out_allowed_dy,
  output logic        [scr_pkg::LEN_W-1:0]    out_move_length,
  output logic                                out_replaced,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [scr_pkg::SIZE_W-1:0]   cfg_data
);
  import scr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_R2, S_BEST, S_SW_INIT, S_SW_LEN, S_SW_T0, S_DIV_GO, S_DIV_WAIT,
    S_CO_CHK, S_CO_T, S_CO_END, S_CO_ET, S_REF_INIT, S_REF_STEP, S_REF_T,
    S_FIN, S_FIN_LEN, S_SW_END, S_OUT, S_T_CLAMP, S_SQ1, S_SQ2
  } state_t;

  state_t state_r, ret_r;

  // configuration
  logic [SIZE_W-1:0] mhs_r;

  // request
  logic signed [COORD_W-1:0] rx_r, ry_r;
  logic [SIZE_W-1:0]         hw_r, hh_r, rad_r;
  logic signed [MOVE_W-1:0]  dx_r, dy_r;
  logic [LEN_W-1:0]          prior_r;
  logic [LEN_W-1:0]          r2_r;
  sum_t                      best_r;

  // sweep
  logic [1:0]   sweep_r;
  pos_t         ssx_r, ssy_r, px_r, py_r, cx_r, cy_r;
  off_t         sox_r, soy_r, stx_r, sty_r, rox_r, roy_r, remy_r;
  logic         hit_r;
  sum_t         len_r;
  logic [SIZE_W-1:0] so_r;
  logic [DIV_W-1:0]  ax_r, step_r, cnt_r;
  logic [1:0]   dsel_r;

  // squarer and contact test
  mag_t         sqa_r, sqb_r;
  sum_t         sq_r, sum_r;
  logic         farx_r, fary_r;

  // output register
  logic                       ovalid_r;
  logic                       ohit_r, orepl_r;
  logic signed [COORD_W-1:0]  oex_r, oey_r;
  logic signed [MOVE_W-1:0]   oax_r, oay_r;
  logic [LEN_W-1:0]           olen_r;

  // shared squarer
  mag_t mul_a;
  sum_t prod;
  assign mul_a = (state_r == S_SQ1) ? sqa_r : sqb_r;
  assign prod  = SUM_W'(mul_a) * SUM_W'(mul_a);

  logic touch_hit;
  assign touch_hit = !farx_r && !fary_r && (sum_r <= SUM_W'(r2_r));

  // distance from the rectangle outside its extent, per axis
  diff_t ddx, ddy, hwx, hhy, magx, magy;
  assign ddx = diff_t'(cx_r) - diff_t'(rx_r);
  assign ddy = diff_t'(cy_r) - diff_t'(ry_r);
  assign hwx = diff_t'({1'b0, hw_r});
  assign hhy = diff_t'({1'b0, hh_r});

  always_comb begin
    if (ddx > hwx)       magx = ddx - hwx;
    else if (ddx < -hwx) magx = -ddx - hwx;
    else                 magx = '0;
    if (ddy > hhy)       magy = ddy - hhy;
    else if (ddy < -hhy) magy = -ddy - hhy;
    else                 magy = '0;
  end

  // coarse step size: smallest size, raised to the register and to one
  logic [SIZE_W-1:0] so_min, so_val;
  always_comb begin
    so_min = rad_r;
    if (hw_r < so_min) so_min = hw_r;
    if (hh_r < so_min) so_min = hh_r;
    so_val = (so_min < mhs_r) ? mhs_r : so_min;
    if (so_val == '0) so_val = SIZE_W'(1);
  end

  // divider
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_a, div_b, div_q;
  assign div_start = (state_r == S_DIV_GO);

  always_comb begin
    unique case (dsel_r)
      2'd0: begin div_a = off_abs(sox_r); div_b = DIV_W'(so_r); end
      2'd1: begin div_a = off_abs(soy_r); div_b = DIV_W'(so_r); end
      2'd2: begin div_a = off_abs(sox_r); div_b = step_r; end
      default: begin div_a = off_abs(soy_r); div_b = step_r; end
    endcase
  end

  scr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // signed quotient, truncated toward zero
  off_t q_sgn;
  always_comb begin
    if (dsel_r == 2'd2) q_sgn = sox_r[OFF_W-1] ? -off_t'(div_q) : off_t'(div_q);
    else                q_sgn = soy_r[OFF_W-1] ? -off_t'(div_q) : off_t'(div_q);
  end

  // refinement: halve on contact, rounding toward minus infinity
  off_t stx_n, sty_n;
  assign stx_n = touch_hit ? (stx_r >>> 1) : stx_r;
  assign sty_n = touch_hit ? (sty_r >>> 1) : sty_r;

  // final offset, limited to the offset magnitude
  diff_t fdx, fdy, limx, limy;
  off_t  fx, fy;
  assign fdx  = diff_t'(px_r) - diff_t'(ssx_r);
  assign fdy  = diff_t'(py_r) - diff_t'(ssy_r);
  assign limx = diff_t'(off_abs(sox_r));
  assign limy = diff_t'(off_abs(soy_r));
  always_comb begin
    if (fdx > limx)       fx = off_t'(limx);
    else if (fdx < -limx) fx = off_t'(-limx);
    else                  fx = off_t'(fdx);
    if (fdy > limy)       fy = off_t'(limy);
    else if (fdy < -limy) fy = off_t'(-limy);
    else                  fy = off_t'(fdy);
  end

  sum_t best_m, fbest;
  assign best_m = (len_r < best_r) ? len_r : best_r;
  assign fbest  = best_m;

  logic [DIV_W-1:0] step_q;
  always_comb begin
    step_q = (ax_r >= div_q) ? ax_r : div_q;
    if (step_q == '0) step_q = DIV_W'(1);
  end

  off_t remx;
  assign remx = off_t'(dx_r) - rox_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_IDLE;
      mhs_r    <= SIZE_W'(1);
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_valid) mhs_r <= cfg_data;
      // the output state reloads the result register itself
      if (ovalid_r && out_ready && state_r != S_OUT) ovalid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ssx_r   <= pos_t'(in_circle_x);
            ssy_r   <= pos_t'(in_circle_y);
            rx_r    <= in_rect_x;
            ry_r    <= in_rect_y;
            hw_r    <= in_rect_half_w;
            hh_r    <= in_rect_half_h;
            dx_r    <= in_move_dx;
            dy_r    <= in_move_dy;
            prior_r <= in_prior_length;
            rad_r   <= (in_circle_radius < mhs_r) ? mhs_r : in_circle_radius;
            sqa_r   <= (in_circle_radius < mhs_r) ? MAG_W'(mhs_r) : MAG_W'(in_circle_radius);
            sqb_r   <= '0;
            ret_r   <= S_R2;
            state_r <= S_SQ1;
          end
        end
        S_R2: begin
          r2_r    <= LEN_W'(sum_r);
          sqa_r   <= off_abs(off_t'(dx_r));
          sqb_r   <= off_abs(off_t'(dy_r));
          ret_r   <= S_BEST;
          state_r <= S_SQ1;
        end
        S_BEST: begin
          best_r  <= sum_r;
          sweep_r <= 2'd0;
          sox_r   <= off_t'(dx_r);
          soy_r   <= off_t'(dy_r);
          state_r <= S_SW_INIT;
        end
        S_SW_INIT: begin
          hit_r <= 1'b0;
          rox_r <= '0;
          roy_r <= '0;
          px_r  <= ssx_r;
          py_r  <= ssy_r;
          cx_r  <= ssx_r;
          cy_r  <= ssy_r;
          if (sox_r == '0 && soy_r == '0) begin
            len_r   <= '0;
            state_r <= S_SW_END;
          end else begin
            sqa_r   <= off_abs(sox_r);
            sqb_r   <= off_abs(soy_r);
            ret_r   <= S_SW_LEN;
            state_r <= S_SQ1;
          end
        end
        S_SW_LEN: begin
          len_r   <= sum_r;
          ret_r   <= S_SW_T0;
          state_r <= S_T_CLAMP;
        end
        S_SW_T0: begin
          // already touching: stay at the start
          if (touch_hit) begin
            hit_r   <= 1'b1;
            state_r <= S_SW_END;
          end else begin
            so_r    <= so_val;
            dsel_r  <= 2'd0;
            state_r <= S_DIV_GO;
          end
        end
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            unique case (dsel_r)
              2'd0: begin
                ax_r    <= div_q;
                dsel_r  <= 2'd1;
                state_r <= S_DIV_GO;
              end
              2'd1: begin
                step_r  <= step_q;
                dsel_r  <= 2'd2;
                state_r <= S_DIV_GO;
              end
              2'd2: begin
                stx_r   <= q_sgn;
                dsel_r  <= 2'd3;
                state_r <= S_DIV_GO;
              end
              default: begin
                sty_r   <= q_sgn;
                cnt_r   <= '0;
                state_r <= S_CO_CHK;
              end
            endcase
          end
        end
        S_CO_CHK: begin
          if (cnt_r == step_r) begin
            state_r <= S_CO_END;
          end else begin
            ret_r   <= S_CO_T;
            state_r <= S_T_CLAMP;
          end
        end
        S_CO_T: begin
          if (touch_hit) begin
            state_r <= S_REF_INIT;
          end else begin
            px_r    <= cx_r;
            py_r    <= cy_r;
            cx_r    <= cx_r + pos_t'(stx_r);
            cy_r    <= cy_r + pos_t'(sty_r);
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_CO_CHK;
          end
        end
        S_CO_END: begin
          cx_r    <= ssx_r + pos_t'(sox_r);
          cy_r    <= ssy_r + pos_t'(soy_r);
          ret_r   <= S_CO_ET;
          state_r <= S_T_CLAMP;
        end
        S_CO_ET: begin
          // end of the move is free: whole offset allowed
          if (!touch_hit) begin
            px_r    <= cx_r;
            py_r    <= cy_r;
            rox_r   <= sox_r;
            roy_r   <= soy_r;
            state_r <= S_SW_END;
          end else begin
            state_r <= S_REF_INIT;
          end
        end
        S_REF_INIT: begin
          stx_r   <= stx_r >>> 1;
          sty_r   <= sty_r >>> 1;
          cx_r    <= px_r;
          cy_r    <= py_r;
          cnt_r   <= '0;
          state_r <= S_REF_STEP;
        end
        S_REF_STEP: begin
          cx_r    <= cx_r + pos_t'(stx_r);
          cy_r    <= cy_r + pos_t'(sty_r);
          ret_r   <= S_REF_T;
          state_r <= S_T_CLAMP;
        end
        S_REF_T: begin
          stx_r <= stx_n;
          sty_r <= sty_n;
          if (touch_hit) begin
            cx_r <= px_r;
            cy_r <= py_r;
          end else begin
            px_r <= cx_r;
            py_r <= cy_r;
          end
          if ((stx_n == '0 && sty_n == '0) ||
              cnt_r == DIV_W'(SMALL_STEP_ITERS - 1)) begin
            state_r <= S_FIN;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_REF_STEP;
          end
        end
        S_FIN: begin
          rox_r   <= fx;
          roy_r   <= fy;
          px_r    <= ssx_r + pos_t'(fx);
          py_r    <= ssy_r + pos_t'(fy);
          hit_r   <= 1'b1;
          sqa_r   <= off_abs(fx);
          sqb_r   <= off_abs(fy);
          ret_r   <= S_FIN_LEN;
          state_r <= S_SQ1;
        end
        S_FIN_LEN: begin
          len_r   <= sum_r;
          state_r <= S_SW_END;
        end
        S_SW_END: begin
          // on a hit, sweep the leftover x part, then the leftover y part
          if (hit_r && sweep_r != 2'd2) begin
            best_r  <= best_m;
            ssx_r   <= px_r;
            ssy_r   <= py_r;
            sweep_r <= sweep_r + 1'b1;
            if (sweep_r == 2'd0) begin
              sox_r  <= remx;
              soy_r  <= '0;
              remy_r <= off_t'(dy_r) - roy_r;
            end else begin
              sox_r <= '0;
              soy_r <= remy_r;
            end
            state_r <= S_SW_INIT;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ovalid_r || out_ready) begin
            ovalid_r <= 1'b1;
            ohit_r   <= hit_r;
            oex_r    <= px_r[COORD_W-1:0];
            oey_r    <= py_r[COORD_W-1:0];
            oax_r    <= rox_r[MOVE_W-1:0];
            oay_r    <= roy_r[MOVE_W-1:0];
            olen_r   <= len_r[LEN_W-1:0];
            orepl_r  <= fbest <= SUM_W'(prior_r);
            state_r  <= S_IDLE;
          end
        end
        S_T_CLAMP: begin
          // beyond 16 bits of gap the square exceeds any radius squared
          farx_r  <= magx[DIFF_W-1:SIZE_W] != '0;
          fary_r  <= magy[DIFF_W-1:SIZE_W] != '0;
          sqa_r   <= MAG_W'(magx[SIZE_W-1:0]);
          sqb_r   <= MAG_W'(magy[SIZE_W-1:0]);
          state_r <= S_SQ1;
        end
        S_SQ1: begin
          sq_r    <= prod;
          state_r <= S_SQ2;
        end
        S_SQ2: begin
          sum_r   <= sq_r + prod;
          state_r <= ret_r;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = ovalid_r;
  assign out_hit         = ohit_r;
  assign out_end_x       = oex_r;
  assign out_end_y       = oey_r;
  assign out_allowed_dx  = oax_r;
  assign out_allowed_dy  = oay_r;
  assign out_move_length = olen_r;
  assign out_replaced    = orepl_r;

  // an accepted request always leaves idle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted but block stayed idle");

  // the divider is never restarted while it runs
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV_GO |=> state_r == S_DIV_WAIT && !div_done)
    else $error("divider sequencing broken");

  // coarse walk never passes the step count
  a_coarse_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CO_CHK |-> cnt_r <= step_r)
    else $error("coarse step count overran");

  // a result only appears from the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside output state");

endmodule

// File: sim/swept_circle_rect_collision_tb.sv
`timescale 1ns / 1ps

module swept_circle_rect_collision_tb;
  import scr_pkg::*;

  localparam int unsigned STALL_LIMIT = 8000000;  // cycles with no handshake
  localparam int          REFINE_ITERS = 16;

  // one collision query as driven on the input channel
  typedef struct {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic        [SIZE_W-1:0]  radius;
    logic signed [COORD_W-1:0] rx;
    logic signed [COORD_W-1:0] ry;
    logic        [SIZE_W-1:0]  half_w;
    logic        [SIZE_W-1:0]  half_h;
    logic signed [MOVE_W-1:0]  dx;
    logic signed [MOVE_W-1:0]  dy;
    logic        [LEN_W-1:0]   prior;
  } query_t;

  // one collision verdict as seen on the result channel
  typedef struct {
    logic                      hit;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [MOVE_W-1:0]  allow_dx;
    logic signed [MOVE_W-1:0]  allow_dy;
    logic        [LEN_W-1:0]   length;
    logic                      replaced;
  } verdict_t;

  // outcome of one sweep, kept exact
  typedef struct {
    bit     hit;
    longint px;
    longint py;
    longint ox;
    longint oy;
    longint len;
  } sweep_t;

  class collision_scoreboard;
    longint   min_half;
    verdict_t verdicts_due[$];
    int       errors;
    longint   rect_x, rect_y, half_w, half_h, radius;

    function new();
      min_half = 1;
      errors = 0;
    endfunction

    function longint sq_len(longint x, longint y);
      return x * x + y * y;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    // halving rounds toward minus infinity
    function longint halve(longint v);
      return v >= 0 ? v / 2 : -((-v + 1) / 2);
    endfunction

    function bit touches(longint px, longint py);
      longint ex, ey;
      ex = px - rect_x;
      ey = py - rect_y;
      ex = ex - clamp(ex, -half_w, half_w);
      ey = ey - clamp(ey, -half_h, half_h);
      return sq_len(ex, ey) <= radius * radius;
    endfunction

    function sweep_t sweep(longint sx, longint sy, longint ox, longint oy);
      sweep_t s;
      longint so, steps, stx, sty, x, y, fx, fy;
      bit     blocked;
      s.hit = 0;
      s.ox = 0;
      s.oy = 0;
      s.px = sx;
      s.py = sy;
      s.len = sq_len(ox, oy);
      if (ox == 0 && oy == 0) return s;
      if (touches(sx, sy)) begin
        s.hit = 1;
        return s;
      end
      // coarse step divisor: smallest size, raised to the minimum half size and to one
      so = radius;
      if (half_w < so) so = half_w;
      if (half_h < so) so = half_h;
      if (so < min_half) so = min_half;
      if (so < 1) so = 1;
      steps = mag(ox) / so;
      if (mag(oy) / so > steps) steps = mag(oy) / so;
      if (steps < 1) steps = 1;
      stx = ox / steps;
      sty = oy / steps;
      x = sx;
      y = sy;
      blocked = 0;
      for (longint i = 0; i < steps; i++) begin
        if (touches(x, y)) begin
          blocked = 1;
          break;
        end
        s.px = x;
        s.py = y;
        x += stx;
        y += sty;
      end
      if (!blocked && !touches(sx + ox, sy + oy)) begin
        s.px = sx + ox;
        s.py = sy + oy;
        s.ox = ox;
        s.oy = oy;
        return s;
      end
      // refine from the last free position with halving steps
      stx = halve(stx);
      sty = halve(sty);
      x = s.px;
      y = s.py;
      for (int i = 0; i < REFINE_ITERS; i++) begin
        x += stx;
        y += sty;
        if (touches(x, y)) begin
          x = s.px;
          y = s.py;
          stx = halve(stx);
          sty = halve(sty);
        end else begin
          s.px = x;
          s.py = y;
        end
        if (stx == 0 && sty == 0) break;
      end
      fx = clamp(x - sx, -mag(ox), mag(ox));
      fy = clamp(y - sy, -mag(oy), mag(oy));
      s.ox = fx;
      s.oy = fy;
      s.px = sx + fx;
      s.py = sy + fy;
      s.len = sq_len(fx, fy);
      s.hit = 1;
      return s;
    endfunction

    // accepted request: work out its verdict and queue it
    function void note_query(query_t q);
      sweep_t   s;
      verdict_t v;
      longint   dx, dy, best;
      dx = longint'(q.dx);
      dy = longint'(q.dy);
      radius = longint'(q.radius);
      if (radius < min_half) radius = min_half;
      rect_x = longint'(q.rx);
      rect_y = longint'(q.ry);
      half_w = longint'(q.half_w);
      half_h = longint'(q.half_h);
      best = sq_len(dx, dy);
      s = sweep(longint'(q.cx), longint'(q.cy), dx, dy);
      if (s.hit) begin
        longint remx, remy;
        remx = dx - s.ox;
        remy = dy - s.oy;
        if (s.len < best) best = s.len;
        // slide along the leftover x part, then the leftover y part
        s = sweep(s.px, s.py, remx, 0);
        if (s.hit) begin
          if (s.len < best) best = s.len;
          s = sweep(s.px, s.py, 0, remy);
        end
      end
      if (s.len < best) best = s.len;
      v.hit = s.hit;
      v.end_x = s.px[COORD_W-1:0];
      v.end_y = s.py[COORD_W-1:0];
      v.allow_dx = s.ox[MOVE_W-1:0];
      v.allow_dy = s.oy[MOVE_W-1:0];
      v.length = s.len[LEN_W-1:0];
      v.replaced = best <= longint'(q.prior);
      verdicts_due.push_back(v);
    endfunction

    function void compare(string field, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      end
    endfunction

    function void check_verdict(verdict_t a);
      verdict_t e;
      if (verdicts_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected verdict, expected none, actual end %0d,%0d", $time,
                 a.end_x, a.end_y);
        return;
      end
      e = verdicts_due.pop_front();
      compare("hit", e.hit, a.hit);
      compare("end_x", e.end_x, a.end_x);
      compare("end_y", e.end_y, a.end_y);
      compare("allowed_dx", e.allow_dx, a.allow_dx);
      compare("allowed_dy", e.allow_dy, a.allow_dy);
      compare("move_length", e.length, a.length);
      compare("replaced", e.replaced, a.replaced);
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  query_t                    req;
  logic                      out_valid;
  logic                      out_ready;
  logic                      out_hit;
  logic signed [COORD_W-1:0] out_end_x;
  logic signed [COORD_W-1:0] out_end_y;
  logic signed [MOVE_W-1:0]  out_allowed_dx;
  logic signed [MOVE_W-1:0]  out_allowed_dy;
  logic        [LEN_W-1:0]   out_move_length;
  logic                      out_replaced;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic        [SIZE_W-1:0]  cfg_data;

  collision_scoreboard sb;
  int unsigned send_idle_pct;  // chance per cycle that the sender idles
  int unsigned recv_stall_pct; // chance per cycle that the receiver stalls
  bit          recv_hold;      // long receiver hold-off in progress
  int unsigned quiet_cycles;

  swept_circle_rect_collision dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_circle_x      (req.cx),
    .in_circle_y      (req.cy),
    .in_circle_radius (req.radius),
    .in_rect_x        (req.rx),
    .in_rect_y        (req.ry),
    .in_rect_half_w   (req.half_w),
    .in_rect_half_h   (req.half_h),
    .in_move_dx       (req.dx),
    .in_move_dy       (req.dy),
    .in_prior_length  (req.prior),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_end_x        (out_end_x),
    .out_end_y        (out_end_y),
    .out_allowed_dx   (out_allowed_dx),
    .out_allowed_dy   (out_allowed_dy),
    .out_move_length  (out_move_length),
    .out_replaced     (out_replaced),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver: ready changes on the falling edge
  always @(negedge clk) begin
    out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // check every accepted verdict at the rising edge
  always @(posedge clk) begin
    verdict_t a;
    if (rst_n && out_valid && out_ready) begin
      a.hit = out_hit;
      a.end_x = out_end_x;
      a.end_y = out_end_y;
      a.allow_dx = out_allowed_dx;
      a.allow_dy = out_allowed_dy;
      a.length = out_move_length;
      a.replaced = out_replaced;
      sb.check_verdict(a);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic query_t make_query(longint cx, longint cy, longint r, longint rx,
                                        longint ry, longint hw, longint hh, longint dx,
                                        longint dy, longint prior);
    query_t q;
    q.cx = cx[COORD_W-1:0];
    q.cy = cy[COORD_W-1:0];
    q.radius = r[SIZE_W-1:0];
    q.rx = rx[COORD_W-1:0];
    q.ry = ry[COORD_W-1:0];
    q.half_w = hw[SIZE_W-1:0];
    q.half_h = hh[SIZE_W-1:0];
    q.dx = dx[MOVE_W-1:0];
    q.dy = dy[MOVE_W-1:0];
    q.prior = prior[LEN_W-1:0];
    return q;
  endfunction

  // random request; the move is kept to a few dozen coarse steps
  function automatic query_t random_query(longint min_half);
    longint scale, r, hw, hh, so, lim, rx, ry, offx, offy, dx, dy, prior, reach;
    int unsigned pick;
    pick = $urandom_range(99);
    case ($urandom_range(3))
      0: scale = 16;
      1: scale = 256;
      2: scale = 4096;
      default: scale = 65535;
    endcase
    if (pick < 10) begin
      // noise: sizes over the whole field
      r = $urandom_range(65535);
      hw = $urandom_range(65535);
      hh = $urandom_range(65535);
    end else begin
      r = $urandom_range(scale, 1);
      hw = $urandom_range(scale, 1);
      hh = $urandom_range(scale, 1);
    end
    so = r;
    if (hw < so) so = hw;
    if (hh < so) so = hh;
    if (so < min_half) so = min_half;
    if (so < 1) so = 1;
    lim = so * 24;
    if (lim > 32767) lim = 32767;
    // rectangle anywhere, sometimes near the coordinate extremes
    if ($urandom_range(9) == 0) begin
      rx = $urandom_range(1) ? 8388607 - $urandom_range(70000)
                             : -8388608 + $urandom_range(70000);
      ry = $urandom_range(1) ? 8388607 - $urandom_range(70000)
                             : -8388608 + $urandom_range(70000);
    end else begin
      rx = longint'($signed(24'($urandom)));
      ry = longint'($signed(24'($urandom)));
    end
    reach = hw + r + lim;
    offx = longint'($urandom_range(2 * reach)) - reach;
    reach = hh + r + lim;
    offy = longint'($urandom_range(2 * reach)) - reach;
    if (pick < 70 && pick >= 10) begin
      // aim the move at the rectangle, with some jitter
      dx = -offx + longint'($urandom_range(2 * so)) - so;
      dy = -offy + longint'($urandom_range(2 * so)) - so;
      if (dx > lim) dx = lim;
      if (dx < -lim) dx = -lim;
      if (dy > lim) dy = lim;
      if (dy < -lim) dy = -lim;
    end else begin
      dx = longint'($urandom_range(2 * lim)) - lim;
      dy = longint'($urandom_range(2 * lim)) - lim;
      if (lim == 32767 && $urandom_range(7) == 0) dx = -32768;
    end
    if ($urandom_range(9) == 0) dx = 0;
    if ($urandom_range(9) == 0) dy = 0;
    if ($urandom_range(1)) prior = $urandom;
    else prior = $urandom_range(dx * dx + dy * dy);
    return make_query(rx + offx, ry + offy, r, rx, ry, hw, hh, dx, dy, prior);
  endfunction

  // offer one request from a falling edge and hold it until it is taken
  task automatic send_query(query_t q);
    in_valid = 1'b1;
    req = q;
    do @(posedge clk); while (!in_ready);
    sb.note_query(q);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
  endtask

  // wait until every verdict is in, then let the block settle
  task automatic drain();
    in_valid = 1'b0;
    while (sb.verdicts_due.size() != 0) @(posedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_min_half(logic [SIZE_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    sb.min_half = longint'(value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 81;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 81;
      end
      default: begin
        send_idle_pct = 14;
        recv_stall_pct = 14;
      end
    endcase
  endtask

  longint min_half_plan[6] = '{1, 65535, 0, 300, 37, 1};

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    req = make_query(0, 0, 1, 0, 0, 1, 1, 0, 0, 0);
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    recv_hold = 1'b0;
    quiet_cycles = 0;
    set_idling(0);
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed requests at the reset setting
    send_query(make_query(0, 0, 10, 1000, 1000, 50, 50, 0, 0, 0));           // zero move
    send_query(make_query(0, 0, 10, 5, 0, 10, 10, 100, 50, 32'hffffffff));   // already touching
    send_query(make_query(-500, 0, 20, 0, 0, 100, 100, 1000, 0, 1000000));   // straight hit
    send_query(make_query(500, 30, 20, 0, 0, 100, 100, -1000, -7, 5));       // negative halving
    send_query(make_query(-300, -300, 40, 0, 0, 100, 100, 600, 500, 90000)); // slide
    send_query(make_query(-200, -200, 10, 0, 0, 50, 50, 300, 300, 0));       // corner
    send_query(make_query(0, -40000, 100, 0, 0, 200, 200, 0, 32767, 1));
    send_query(make_query(8388607, -8388608, 65535, -8388608, 8388607, 65535, 65535,
                          32767, -32768, 32'hffffffff));
    send_query(make_query(8388600, 0, 5, -100, 0, 3, 3, 32767, 0, 32'h80000000));  // wraps
    send_query(make_query(-8388608, 100, 7, 0, 0, 9, 9, -32768, 0, 0));
    send_query(make_query(0, 0, 1, 8000000, 8000000, 1, 1, 32767, -32768, 0));   // many steps
    send_query(make_query(-60, 3, 65535, 0, 0, 1, 65535, 50, -20, 2500));
    send_query(make_query(100, 100, 5, 0, 0, 20, 20, -140, -131, 300));
    drain();

    // zero step size: register at 0 and a zero half size
    write_min_half(0);
    send_query(make_query(-50, 0, 0, 0, 0, 0, 5, 100, 0, 40));
    send_query(make_query(-30, -30, 0, 0, 0, 0, 0, 60, 61, 0));
    send_query(make_query(10, -40, 3, 0, 0, 0, 20, -5, 80, 32'hffffffff));
    drain();

    // random phases over several register settings and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      write_min_half(min_half_plan[ph][SIZE_W-1:0]);
      for (int mode = 0; mode < 4; mode++) begin
        set_idling(mode);
        if (ph == 0 && mode == 0) begin
          // long receiver hold-off while requests keep coming
          fork
            begin
              recv_hold = 1'b1;
              repeat (400) @(negedge clk);
              recv_hold = 1'b0;
            end
          join_none
        end
        for (int n = 0; n < 70; n++) send_query(random_query(sb.min_half));
      end
      drain();
    end

    set_idling(0);
    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.verdicts_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/scr_pkg.sv
rtl/scr_div.sv
rtl/swept_circle_rect_collision.sv
sim/swept_circle_rect_collision_tb.sv
